// File: rtl/lfy_pkg.sv
// Shared constants and interface types for the LCG-driven permutation table.
// No dependencies; used by every module under rtl.
package lfy_pkg;

	localparam int SEED_W          = 32;
	localparam int ID_W            = 6;
	localparam int CNT_W           = 7;
	localparam int MAX_ENTRIES_DEF = 64;

	localparam logic [CNT_W-1:0]  ACTIVE_COUNT_RST = 7'd64;
	localparam logic [SEED_W-1:0] LCG_MUL          = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD          = 32'd1013904223;

	localparam logic OP_SHUFFLE = 1'b0;
	localparam logic OP_LOOKUP  = 1'b1;

	typedef struct packed {
		logic              start;
		logic [SEED_W-1:0] dividend;
		logic [CNT_W-1:0]  divisor;
	} mod_ctl_t;

	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} mod_sts_t;

endpackage

// File: rtl/lfy_mod.sv
// Bit-serial remainder unit: 32-bit dividend modulo a 7-bit divisor, one bit a cycle.
// Depends on lfy_pkg.
module lfy_mod (
	input  logic              clk,
	input  logic              arst_n,
	input  lfy_pkg::mod_ctl_t ctl,
	output lfy_pkg::mod_sts_t sts
);

	localparam int STEP_W = $clog2(lfy_pkg::SEED_W);

	logic [lfy_pkg::SEED_W-1:0] dvd_q;
	logic [lfy_pkg::CNT_W-1:0]  div_q;
	logic [lfy_pkg::CNT_W-1:0]  rem_q;
	logic [STEP_W-1:0]          cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [lfy_pkg::CNT_W:0]    trial;
	logic [lfy_pkg::CNT_W:0]    diff;
	logic [lfy_pkg::CNT_W-1:0]  rem_nxt;

	assign trial   = {rem_q, dvd_q[lfy_pkg::SEED_W-1]};
	assign diff    = trial - {1'b0, div_q};
	assign rem_nxt = (trial >= {1'b0, div_q}) ? diff[lfy_pkg::CNT_W-1:0]
	                                          : trial[lfy_pkg::CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == STEP_W'(lfy_pkg::SEED_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= ctl.dividend;
			div_q <= ctl.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[lfy_pkg::SEED_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign sts.done = done_q;
	assign sts.rem  = rem_q;

endmodule

// File: rtl/lfy_tbl.sv
// Permutation table memory: one write port, one registered read port.
// Depends on lfy_pkg for the default depth.
module lfy_tbl #(
	parameter int MAX_ENTRIES = lfy_pkg::MAX_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(MAX_ENTRIES)-1:0] waddr,
	input  logic [$clog2(MAX_ENTRIES)-1:0] wdata,
	input  logic [$clog2(MAX_ENTRIES)-1:0] raddr,
	output logic [$clog2(MAX_ENTRIES)-1:0] rdata
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	logic [IDX_W-1:0] mem [MAX_ENTRIES];
	logic [IDX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lcg_fisher_yates_permutation.sv
// Permutation table shuffled by Fisher-Yates with an LCG seed, plus entry lookup.
// Lookup: read in ST_LKRD, captured in ST_LKCAP, registered out in ST_PUSH; no new op is
// accepted until ST_PUSH hands off. Shuffle: identity fill of all entries, then n-1 swaps,
// each paced by the 32-step serial remainder unit and the table's one read and one write port.
// Reset: identity fill pass over all MAX_ENTRIES entries with in_stall high; active_count = 64.
// Depends on lfy_pkg, lfy_mod, lfy_tbl.
module lcg_fisher_yates_permutation #(
	parameter int MAX_ENTRIES = lfy_pkg::MAX_ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lfy_pkg::CNT_W-1:0]  cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [lfy_pkg::SEED_W-1:0] seed,
	input  logic [lfy_pkg::ID_W-1:0]   index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [lfy_pkg::ID_W-1:0]   mapped_id,
	output logic                       out_of_range
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CW    = lfy_pkg::CNT_W;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_FILL  = 11'b00000000010,
		ST_MGO   = 11'b00000000100,
		ST_MRUN  = 11'b00000001000,
		ST_RDI   = 11'b00000010000,
		ST_RDJ   = 11'b00000100000,
		ST_WRI   = 11'b00001000000,
		ST_WRJ   = 11'b00010000000,
		ST_LKRD  = 11'b00100000000,
		ST_LKCAP = 11'b01000000000,
		ST_PUSH  = 11'b10000000000
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              active_count_q;
	logic [CW-1:0]              n_q;
	logic [CW-1:0]              i_q;
	logic [CW-1:0]              j_q;
	logic [lfy_pkg::SEED_W-1:0] seed_q;
	logic [IDX_W-1:0]           fill_q;
	logic [IDX_W-1:0]           vi_q;
	logic [CW-1:0]              idx_q;
	logic                       shuf_q;
	logic [lfy_pkg::ID_W-1:0]   res_id_q;
	logic                       res_oor_q;
	logic                       out_valid_q;
	logic [lfy_pkg::ID_W-1:0]   out_id_q;
	logic                       out_oor_q;

	logic [CW-1:0]              n_eff;
	logic                       in_acc;
	logic                       out_free;
	logic                       tbl_we;
	logic [IDX_W-1:0]           tbl_waddr;
	logic [IDX_W-1:0]           tbl_wdata;
	logic [IDX_W-1:0]           tbl_raddr;
	logic [IDX_W-1:0]           tbl_rdata;
	lfy_pkg::mod_ctl_t          mod_ctl;
	lfy_pkg::mod_sts_t          mod_sts;

	assign n_eff = (32'(active_count_q) > 32'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
	                                                        : active_count_q;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign mod_ctl.start    = (state_q == ST_MGO);
	assign mod_ctl.dividend = seed_q;
	assign mod_ctl.divisor  = n_q - i_q;

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = fill_q;
		tbl_wdata = fill_q;
		tbl_raddr = IDX_W'(idx_q);
		case (state_q)
			ST_FILL: begin
				tbl_we = 1'b1;
			end
			ST_RDI: begin
				tbl_raddr = IDX_W'(i_q);
			end
			ST_RDJ: begin
				tbl_raddr = IDX_W'(j_q);
			end
			ST_WRI: begin
				tbl_we    = 1'b1;
				tbl_waddr = IDX_W'(i_q);
				tbl_wdata = tbl_rdata;
			end
			ST_WRJ: begin
				tbl_we    = 1'b1;
				tbl_waddr = IDX_W'(j_q);
				tbl_wdata = vi_q;
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	lfy_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mod_ctl),
		.sts    (mod_sts)
	);

	lfy_tbl #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_count_q <= lfy_pkg::ACTIVE_COUNT_RST;
		end else if (cfg_we) begin
			active_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			fill_q      <= '0;
			shuf_q      <= 1'b0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_PUSH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op == lfy_pkg::OP_SHUFFLE) begin
							fill_q  <= '0;
							shuf_q  <= 1'b1;
							state_q <= ST_FILL;
						end else begin
							state_q <= ST_LKRD;
						end
					end
				end
				ST_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == IDX_W'(MAX_ENTRIES - 1)) begin
						i_q <= '0;
						if (!shuf_q) begin
							state_q <= ST_IDLE;
						end else if (n_q <= CW'(1)) begin
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_MGO;
						end
					end
				end
				ST_MGO: begin
					state_q <= ST_MRUN;
				end
				ST_MRUN: begin
					if (mod_sts.done) begin
						state_q <= ST_RDI;
					end
				end
				ST_RDI: begin
					state_q <= ST_RDJ;
				end
				ST_RDJ: begin
					state_q <= ST_WRI;
				end
				ST_WRI: begin
					state_q <= ST_WRJ;
				end
				ST_WRJ: begin
					i_q <= i_q + 1'b1;
					if (({1'b0, i_q} + (CW+1)'(2)) < {1'b0, n_q}) begin
						state_q <= ST_MGO;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_LKRD: begin
					state_q <= ST_LKCAP;
				end
				ST_LKCAP: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (out_free) begin
						shuf_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			seed_q    <= seed;
			n_q       <= n_eff;
			idx_q     <= {1'b0, index};
			res_id_q  <= '0;
			res_oor_q <= (op == lfy_pkg::OP_LOOKUP) && !({1'b0, index} < n_eff);
		end
		if ((state_q == ST_MRUN) && mod_sts.done) begin
			j_q    <= i_q + mod_sts.rem;
			seed_q <= 32'(seed_q * lfy_pkg::LCG_MUL + lfy_pkg::LCG_ADD);
		end
		if (state_q == ST_RDJ) begin
			vi_q <= tbl_rdata;
		end
		if (state_q == ST_LKCAP) begin
			res_id_q <= res_oor_q ? '0 : lfy_pkg::ID_W'(tbl_rdata);
		end
		if ((state_q == ST_PUSH) && out_free) begin
			out_id_q  <= res_id_q;
			out_oor_q <= res_oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign mapped_id    = out_id_q;
	assign out_of_range = out_oor_q;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the LCG-seeded Fisher-Yates permutation table: shuffles,
// lookups and active_count settings, with a scoreboard that holds its own table copy.
// Depends on lfy_pkg and lcg_fisher_yates_permutation.
module testbench;

	localparam int unsigned TABLE_DEPTH = 64;
	localparam int unsigned STALL_LIMIT = 20000;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned RANDOM_PHASES = 13;
	localparam int unsigned PHASE_ITEMS = 133;

	typedef struct packed {
		logic [lfy_pkg::ID_W-1:0] mapped_id;
		logic                     out_of_range;
	} lookup_reply_t;

	class perm_scoreboard;
		logic [lfy_pkg::ID_W-1:0]   perm_ids[TABLE_DEPTH];
		logic [lfy_pkg::SEED_W-1:0] lcg_seed;
		logic [lfy_pkg::CNT_W-1:0]  active_count;
		lookup_reply_t              replies[$];
		int                         errors;

		function new();
			foreach (perm_ids[k]) perm_ids[k] = lfy_pkg::ID_W'(k);
			lcg_seed = '0;
			active_count = lfy_pkg::ACTIVE_COUNT_RST;
			errors = 0;
		endfunction

		function int unsigned live_count();
			return (active_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(active_count);
		endfunction

		function void set_count(logic [lfy_pkg::CNT_W-1:0] value);
			active_count = value;
		endfunction

		function void note_item(logic op_code, logic [lfy_pkg::SEED_W-1:0] start_seed,
				logic [lfy_pkg::ID_W-1:0] idx);
			lookup_reply_t              r;
			int unsigned                n;
			int unsigned                j;
			logic [lfy_pkg::SEED_W-1:0] s;
			logic [lfy_pkg::ID_W-1:0]   t;
			n = live_count();
			r = '0;
			if (op_code == lfy_pkg::OP_SHUFFLE) begin
				foreach (perm_ids[k]) perm_ids[k] = lfy_pkg::ID_W'(k);
				s = start_seed;
				for (int unsigned i = 0; i + 1 < n; i++) begin
					j = i + s % (n - i);
					s = s * lfy_pkg::LCG_MUL + lfy_pkg::LCG_ADD;
					t = perm_ids[i];
					perm_ids[i] = perm_ids[j];
					perm_ids[j] = t;
				end
				lcg_seed = s;
			end else if (idx < n) begin
				r.mapped_id = perm_ids[idx];
			end else begin
				r.out_of_range = 1'b1;
			end
			replies.push_back(r);
		endfunction

		function void check_reply(logic [lfy_pkg::ID_W-1:0] got_id, logic got_oor);
			lookup_reply_t exp_r;
			if (replies.size() == 0) begin
				$display("%0t: unexpected transaction mapped_id=%0d out_of_range=%0b",
					$time, got_id, got_oor);
				errors++;
			end else begin
				exp_r = replies.pop_front();
				if (got_id !== exp_r.mapped_id) begin
					$display("%0t: mapped_id expected %0d actual %0d",
						$time, exp_r.mapped_id, got_id);
					errors++;
				end
				if (got_oor !== exp_r.out_of_range) begin
					$display("%0t: out_of_range expected %0b actual %0b",
						$time, exp_r.out_of_range, got_oor);
					errors++;
				end
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [lfy_pkg::CNT_W-1:0]  cfg_wdata = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       op = lfy_pkg::OP_LOOKUP;
	logic [lfy_pkg::SEED_W-1:0] seed = '0;
	logic [lfy_pkg::ID_W-1:0]   index = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [lfy_pkg::ID_W-1:0]   mapped_id;
	logic                       out_of_range;
	logic                       steady = 1'b0;
	int unsigned                quiet_cycles = 0;

	perm_scoreboard board = new();

	lcg_fisher_yates_permutation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.seed         (seed),
		.index        (index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mapped_id    (mapped_id),
		.out_of_range (out_of_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_reply(mapped_id, out_of_range);
		out_stall <= !steady && ($urandom_range(0, 99) < 16);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic issue_op(input logic op_code, input logic [lfy_pkg::SEED_W-1:0] s,
			input logic [lfy_pkg::ID_W-1:0] idx);
		if (!steady) begin
			while ($urandom_range(0, 99) < 16) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		op <= op_code;
		seed <= s;
		index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_item(op_code, s, idx);
	endtask

	task automatic lookup(input logic [lfy_pkg::ID_W-1:0] idx);
		issue_op(lfy_pkg::OP_LOOKUP, $urandom, idx);
	endtask

	task automatic shuffle(input logic [lfy_pkg::SEED_W-1:0] s);
		issue_op(lfy_pkg::OP_SHUFFLE, s, lfy_pkg::ID_W'($urandom));
	endtask

	task automatic wait_replies_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.replies.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_active_count(input logic [lfy_pkg::CNT_W-1:0] value);
		wait_replies_done();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_count(value);
	endtask

	initial begin
		logic [lfy_pkg::CNT_W-1:0] plan[4];
		int unsigned               n;
		int unsigned               pick;
		plan = '{7'd64, 7'd33, 7'd3, 7'd100};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_active_count(7'd64);
		lookup(6'd0);
		lookup(6'd63);
		shuffle(32'h0000_0000);
		lookup(6'd0);
		lookup(6'd63);
		shuffle(32'hFFFF_FFFF);
		lookup(6'd32);
		write_active_count(7'd1);
		shuffle($urandom);
		lookup(6'd0);
		lookup(6'd1);
		write_active_count(7'd0);
		lookup(6'd0);
		shuffle($urandom);
		lookup(6'd63);
		write_active_count(7'd127);
		shuffle(32'h8000_0001);
		lookup(6'd63);
		lookup(6'd0);
		write_active_count(7'd65);
		lookup(6'd63);
		write_active_count(7'd2);
		shuffle(32'h0000_0001);
		lookup(6'd1);
		lookup(6'd2);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_active_count(p < 4 ? plan[p]
				: lfy_pkg::CNT_W'($urandom_range(1, 64)));
			steady <= (p == 2);
			n = board.live_count();
			shuffle($urandom);
			for (int k = 1; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 2)
					wait_replies_done();
				if (pick >= 2 && pick < 6)
					shuffle($urandom);
				else if (n != 0 && $urandom_range(0, 3) != 0)
					lookup(lfy_pkg::ID_W'($urandom_range(0, n - 1)));
				else
					lookup(lfy_pkg::ID_W'($urandom_range(0, 63)));
			end
		end

		steady <= 1'b0;
		wait_replies_done();
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
